FILE: design/pcs_pkg.sv
// Shared types, constants and helpers for the pump cascade staging unit.
// Used by the interfaces, the controller, the datapath and the top level.
package pcs_pkg;

    // Motor count and the widths that follow from it.
    localparam int MAX_MOTORS = 16;
    localparam int IDX_W      = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int CNT_W      = $clog2(MAX_MOTORS + 1);

    // Fixed field widths.
    localparam int DATA_W    = 16;
    localparam int VAL_W     = DATA_W + 1;
    localparam int TICK_W    = 32;
    localparam int DELAY_W   = 16;
    localparam int TOTAL_W   = 5;
    localparam int OPT_W     = 3;
    localparam int SEED_W    = 4;
    localparam int MASK_W    = 16;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 3;

    // Option bit positions.
    localparam int OPT_BLOCK  = 0;
    localparam int OPT_TARGET = 1;
    localparam int OPT_ENTRY  = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_LIMIT   = 3'd0,
        REG_UNBLOCK_LIMIT = 3'd1,
        REG_STAGE_LIMIT   = 3'd2,
        REG_UNSTAGE_LIMIT = 3'd3,
        REG_STAGE_DELAY   = 3'd4,
        REG_UNSTAGE_DELAY = 3'd5,
        REG_MOTOR_TOTAL   = 3'd6,
        REG_OPTION_BITS   = 3'd7
    } cfg_reg_t;

    // Result event codes.
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_STOP  = 2'd2,
        EV_HELD  = 2'd3
    } event_t;

    // Outcome of a hysteresis band test.
    typedef enum logic [1:0] {
        BAND_HOLD = 2'd0,
        BAND_GO   = 2'd1,
        BAND_STOP = 2'd2
    } band_t;

    // Source of the motor index loaded at the start of a tick.
    typedef enum logic [1:0] {
        IDX_ZERO     = 2'd0,
        IDX_FIRST_ON = 2'd1,
        IDX_NEXT     = 2'd2
    } idx_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     idx_load;
        idx_sel_t idx_sel;
        logic     idx_step;
        logic     motor_write;
        logic     motor_on;
        logic     out_load;
        event_t   out_event;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        band_t block_band;
        band_t target_band;
        logic  opt_block;
        logic  opt_target;
        logic  few_on;
        logic  all_on;
        logic  idx_running;
        logic  idx_last;
        logic  held_stage;
        logic  held_unstage;
        logic  out_free;
    } status_t;

    // Hysteresis band: the on edge lies beyond the off edge in either direction.
    // Equal edges always let motors run.
    function automatic band_t band_of(
        input logic signed [VAL_W-1:0] v,
        input logic signed [VAL_W-1:0] off_lim,
        input logic signed [VAL_W-1:0] on_lim
    );
        band_t b;
        b = BAND_GO;
        if (off_lim > on_lim)
        begin
            if (on_lim > v)
                b = BAND_GO;
            else if (v > off_lim)
                b = BAND_STOP;
            else
                b = BAND_HOLD;
        end
        else if (off_lim < on_lim)
        begin
            if (on_lim < v)
                b = BAND_GO;
            else if (v < off_lim)
                b = BAND_STOP;
            else
                b = BAND_HOLD;
        end
        return b;
    endfunction

endpackage

FILE: design/pcs_if.sv
// Valid/ready channel interfaces for sensor words and motor result words.
// Depends on pcs_pkg for field widths.
interface pcs_sensor_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [pcs_pkg::DATA_W-1:0]        block_temp;
    logic signed [pcs_pkg::DATA_W-1:0]        feed_value;
    logic signed [pcs_pkg::DATA_W-1:0]        entry_value;
    logic        [pcs_pkg::SEED_W-1:0]        start_index;

    modport source (output valid, block_temp, feed_value, entry_value, start_index,
                    input ready);
    modport sink   (input valid, block_temp, feed_value, entry_value, start_index,
                    output ready);
endinterface

interface pcs_motor_if;
    logic                              valid;
    logic                              ready;
    logic [pcs_pkg::MASK_W-1:0]        motor_mask;
    logic [pcs_pkg::EVENT_W-1:0]       tick_event;

    modport source (output valid, motor_mask, tick_event, input ready);
    modport sink   (input valid, motor_mask, tick_event, output ready);
endinterface

FILE: design/pump_cascade_staging_unit.sv
// Pump cascade staging unit: lead/lag staging of up to sixteen pump motors.
// Per word: accept when idle, decide, then scan all motors, step one motor or
// neither, and finish by loading the result word; a held delay ends a scan early.
// Input is accepted only when idle; a waiting result word stalls the input.
// Reset: settings to defaults, all motors off, change marks zero, tick counter 1.
// Depends on pcs_pkg, pcs_if, pcs_ctrl and pcs_dp.
module pump_cascade_staging_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    pcs_sensor_if.sink                        sensor,
    pcs_motor_if.source                       motors,
    input  logic                              cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcs_pkg::DATA_W-1:0]        cfg_data
);

    pcs_pkg::cmd_t    cmd;
    pcs_pkg::status_t status;

    // Sequencer.
    pcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sensor.valid),
        .in_ready (sensor.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage, arithmetic and result register.
    pcs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .block_temp  (sensor.block_temp),
        .feed_value  (sensor.feed_value),
        .entry_value (sensor.entry_value),
        .start_index (sensor.start_index),
        .out_ready   (motors.ready),
        .out_valid   (motors.valid),
        .motor_mask  (motors.motor_mask),
        .tick_event  (motors.tick_event)
    );

endmodule

FILE: design/pcs_ctrl.sv
// Controller state machine for the pump cascade staging unit.
// Depends on pcs_pkg for the command and status structs and event codes.
module pcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pcs_pkg::status_t status,
    output pcs_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SINGLE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MODE_STOP_ALL,
        MODE_START_ALL,
        MODE_UNSTAGE,
        MODE_STAGE
    } mode_t;

    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    pcs_pkg::event_t ev_reg, ev_next;
    logic            stopping;
    logic            relevant;
    logic            held;

    // A stop pass looks at running motors and the unstage delay, a start pass
    // at stopped motors and the stage delay.
    always_comb
    begin
        stopping = (mode_reg == MODE_STOP_ALL) || (mode_reg == MODE_UNSTAGE);
        relevant = stopping ? status.idx_running : !status.idx_running;
        held     = stopping ? status.held_unstage : status.held_stage;
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        ev_next       = ev_reg;
        cmd           = '0;
        cmd.idx_sel   = pcs_pkg::IDX_ZERO;
        cmd.out_event = ev_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ev_next = pcs_pkg::EV_NONE;
                if (status.opt_block && (status.block_band == pcs_pkg::BAND_HOLD))
                begin
                    state_next = S_FINISH;
                end
                else if (status.opt_block && (status.block_band == pcs_pkg::BAND_STOP))
                begin
                    cmd.idx_load = 1'b1;
                    cmd.idx_sel  = pcs_pkg::IDX_ZERO;
                    mode_next    = MODE_STOP_ALL;
                    state_next   = S_SCAN;
                end
                else if (!status.opt_target)
                begin
                    cmd.idx_load = 1'b1;
                    cmd.idx_sel  = pcs_pkg::IDX_ZERO;
                    mode_next    = MODE_START_ALL;
                    state_next   = S_SCAN;
                end
                else if (status.target_band == pcs_pkg::BAND_STOP)
                begin
                    if (status.few_on)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.idx_load = 1'b1;
                        cmd.idx_sel  = pcs_pkg::IDX_FIRST_ON;
                        mode_next    = MODE_UNSTAGE;
                        state_next   = S_SINGLE;
                    end
                end
                else if (status.target_band == pcs_pkg::BAND_GO)
                begin
                    if (status.all_on)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.idx_load = 1'b1;
                        cmd.idx_sel  = pcs_pkg::IDX_NEXT;
                        mode_next    = MODE_STAGE;
                        state_next   = S_SINGLE;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (relevant && held)
                begin
                    ev_next    = pcs_pkg::EV_HELD;
                    state_next = S_FINISH;
                end
                else
                begin
                    if (relevant)
                    begin
                        cmd.motor_write = 1'b1;
                        cmd.motor_on    = !stopping;
                        ev_next         = stopping ? pcs_pkg::EV_STOP : pcs_pkg::EV_START;
                    end
                    if (status.idx_last)
                        state_next = S_FINISH;
                    else
                        cmd.idx_step = 1'b1;
                end
            end
            S_SINGLE:
            begin
                if (held)
                begin
                    ev_next = pcs_pkg::EV_HELD;
                end
                else
                begin
                    cmd.motor_write = 1'b1;
                    cmd.motor_on    = !stopping;
                    ev_next         = stopping ? pcs_pkg::EV_STOP : pcs_pkg::EV_START;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, pass mode and event code.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_STOP_ALL;
            ev_reg    <= pcs_pkg::EV_NONE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ev_reg    <= ev_next;
        end
    end

endmodule

FILE: design/pcs_dp.sv
// Datapath for the pump cascade staging unit: settings, tick counter,
// motor states, change marks, band tests and the result register.
// Depends on pcs_pkg for widths, register indexes and the command/status structs.
module pcs_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pcs_pkg::cmd_t                         cmd,
    output pcs_pkg::status_t                      status,
    input  logic                                  cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pcs_pkg::DATA_W-1:0]            cfg_data,
    input  logic signed [pcs_pkg::DATA_W-1:0]     block_temp,
    input  logic signed [pcs_pkg::DATA_W-1:0]     feed_value,
    input  logic signed [pcs_pkg::DATA_W-1:0]     entry_value,
    input  logic [pcs_pkg::SEED_W-1:0]            start_index,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [pcs_pkg::MASK_W-1:0]            motor_mask,
    output logic [pcs_pkg::EVENT_W-1:0]           tick_event
);

    localparam int IW = pcs_pkg::IDX_W;
    localparam int CW = pcs_pkg::CNT_W;
    localparam int TW = pcs_pkg::TICK_W;

    // Settings.
    logic signed [pcs_pkg::DATA_W-1:0]   block_lim_reg;
    logic signed [pcs_pkg::DATA_W-1:0]   unblock_lim_reg;
    logic signed [pcs_pkg::DATA_W-1:0]   stage_lim_reg;
    logic signed [pcs_pkg::DATA_W-1:0]   unstage_lim_reg;
    logic [pcs_pkg::DELAY_W-1:0]         stage_dly_reg;
    logic [pcs_pkg::DELAY_W-1:0]         unstage_dly_reg;
    logic [pcs_pkg::TOTAL_W-1:0]         total_reg;
    logic [pcs_pkg::OPT_W-1:0]           opt_reg;

    // Captured sensor word.
    logic signed [pcs_pkg::DATA_W-1:0]   temp_reg;
    logic signed [pcs_pkg::DATA_W-1:0]   feed_reg;
    logic signed [pcs_pkg::DATA_W-1:0]   entry_reg;
    logic [pcs_pkg::SEED_W-1:0]          seed_reg;

    // Motor state.
    logic [TW-1:0]                       tick_reg;
    logic [pcs_pkg::MAX_MOTORS-1:0]      running_reg;
    logic [TW-1:0]                       mark_reg [pcs_pkg::MAX_MOTORS];
    logic [IW-1:0]                       idx_reg, idx_next;

    // Result register.
    logic                                out_valid_reg;
    logic [pcs_pkg::MASK_W-1:0]          mask_reg;
    logic [pcs_pkg::EVENT_W-1:0]         event_reg;

    logic [CW-1:0]                       n_eff;
    logic [pcs_pkg::MAX_MOTORS-1:0]      active;
    logic [CW-1:0]                       on_count;
    logic [IW-1:0]                       first_on;
    logic [IW-1:0]                       last_on;
    logic [CW-1:0]                       wrap_base;
    logic [CW-1:0]                       wrap_inc;
    logic [IW-1:0]                       next_pick;
    logic signed [pcs_pkg::VAL_W-1:0]    target_val;
    logic [TW-1:0]                       elapsed;

    // Motors in use: zero acts as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (total_reg == '0)
            n_eff = CW'(1);
        else if (int'(total_reg) > pcs_pkg::MAX_MOTORS)
            n_eff = CW'(pcs_pkg::MAX_MOTORS);
        else
            n_eff = CW'(total_reg);
    end

    // Running motors in use, their count and the lowest and highest of them.
    always_comb
    begin
        on_count = '0;
        first_on = '0;
        last_on  = '0;
        for (int k = 0; k < pcs_pkg::MAX_MOTORS; k++)
        begin
            active[k] = running_reg[k] && (CW'(k) < n_eff);
            on_count  = on_count + CW'(active[k]);
            if (active[k])
                last_on = IW'(k);
        end
        for (int k = pcs_pkg::MAX_MOTORS - 1; k >= 0; k--)
        begin
            if (active[k])
                first_on = IW'(k);
        end
    end

    // Next motor in rotation: after the highest running one, or after the seed
    // when none runs; a seed outside the motors in use picks motor 0.
    always_comb
    begin
        wrap_base = (on_count == '0) ? CW'(seed_reg) : CW'(last_on);
        wrap_inc  = wrap_base + CW'(1);
        if ((on_count == '0) && !(CW'(seed_reg) < n_eff))
            next_pick = '0;
        else if (wrap_inc == n_eff)
            next_pick = '0;
        else
            next_pick = wrap_inc[IW-1:0];
    end

    // Motor index for the current pass.
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_load)
        begin
            case (cmd.idx_sel)
                pcs_pkg::IDX_FIRST_ON: idx_next = first_on;
                pcs_pkg::IDX_NEXT:     idx_next = next_pick;
                default:               idx_next = '0;
            endcase
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    // Band tests and delay checks for the selected motor.
    always_comb
    begin
        target_val = pcs_pkg::VAL_W'(feed_reg);
        if (opt_reg[pcs_pkg::OPT_ENTRY])
            target_val = pcs_pkg::VAL_W'(feed_reg) - pcs_pkg::VAL_W'(entry_reg);
        elapsed = tick_reg - mark_reg[idx_reg];

        status.block_band   = pcs_pkg::band_of(pcs_pkg::VAL_W'(temp_reg),
                                               pcs_pkg::VAL_W'(block_lim_reg),
                                               pcs_pkg::VAL_W'(unblock_lim_reg));
        status.target_band  = pcs_pkg::band_of(target_val,
                                               pcs_pkg::VAL_W'(unstage_lim_reg),
                                               pcs_pkg::VAL_W'(stage_lim_reg));
        status.opt_block    = opt_reg[pcs_pkg::OPT_BLOCK];
        status.opt_target   = opt_reg[pcs_pkg::OPT_TARGET];
        status.few_on       = (on_count <= CW'(1));
        status.all_on       = (on_count == n_eff);
        status.idx_running  = running_reg[idx_reg];
        status.idx_last     = ((CW'(idx_reg) + CW'(1)) == n_eff);
        status.held_stage   = (stage_dly_reg != '0) && (elapsed < TW'(stage_dly_reg));
        status.held_unstage = (unstage_dly_reg != '0) && (elapsed < TW'(unstage_dly_reg));
        status.out_free     = !out_valid_reg || out_ready;
    end

    // Settings and tick counter; a stage delay write reloads the counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_lim_reg   <= '0;
            unblock_lim_reg <= '0;
            stage_lim_reg   <= '0;
            unstage_lim_reg <= '0;
            stage_dly_reg   <= '0;
            unstage_dly_reg <= '0;
            total_reg       <= pcs_pkg::TOTAL_W'(1);
            opt_reg         <= '0;
            tick_reg        <= TW'(1);
        end
        else
        begin
            if (cmd.capture)
                tick_reg <= tick_reg + TW'(1);
            if (cfg_we)
            begin
                unique case (pcs_pkg::cfg_reg_t'(cfg_index))
                    pcs_pkg::REG_BLOCK_LIMIT:   block_lim_reg   <= cfg_data;
                    pcs_pkg::REG_UNBLOCK_LIMIT: unblock_lim_reg <= cfg_data;
                    pcs_pkg::REG_STAGE_LIMIT:   stage_lim_reg   <= cfg_data;
                    pcs_pkg::REG_UNSTAGE_LIMIT: unstage_lim_reg <= cfg_data;
                    pcs_pkg::REG_STAGE_DELAY:
                    begin
                        stage_dly_reg <= cfg_data;
                        tick_reg      <= TW'(cfg_data) + TW'(1);
                    end
                    pcs_pkg::REG_UNSTAGE_DELAY: unstage_dly_reg <= cfg_data;
                    pcs_pkg::REG_MOTOR_TOTAL:   total_reg <= cfg_data[pcs_pkg::TOTAL_W-1:0];
                    pcs_pkg::REG_OPTION_BITS:   opt_reg   <= cfg_data[pcs_pkg::OPT_W-1:0];
                    default:                    opt_reg   <= opt_reg;
                endcase
            end
        end
    end

    // Captured sensor word.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            temp_reg  <= block_temp;
            feed_reg  <= feed_value;
            entry_reg <= entry_value;
            seed_reg  <= start_index;
        end
    end

    // Motor states, change marks and pass index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            idx_reg     <= '0;
            for (int k = 0; k < pcs_pkg::MAX_MOTORS; k++)
                mark_reg[k] <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.motor_write)
            begin
                running_reg[idx_reg] <= cmd.motor_on;
                mark_reg[idx_reg]    <= tick_reg;
            end
        end
    end

    // Result register: a new word may load in the cycle the old one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            mask_reg  <= running_reg[pcs_pkg::MASK_W-1:0];
            event_reg <= cmd.out_event;
        end
    end

    assign out_valid  = out_valid_reg;
    assign motor_mask = mask_reg;
    assign tick_event = event_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the pump cascade staging unit.
// Depends on pcs_pkg, pcs_if and the pump_cascade_staging_unit RTL.
// A directed table runs first, then random phases that use several settings and idle patterns.
`timescale 1ns / 1ps

module tb_top;
    import pcs_pkg::*;

    // Sensor word as driven, and motor word as expected.
    typedef struct {
        logic signed [DATA_W-1:0] block_temp;
        logic signed [DATA_W-1:0] feed_value;
        logic signed [DATA_W-1:0] entry_value;
        logic        [SEED_W-1:0] start_index;
    } sensor_word_t;

    typedef struct {
        logic [MASK_W-1:0] mask;
        event_t            ev;
    } motor_word_t;

    // One row of the directed table: a register write or a sensor word.
    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_reg_t          reg_idx;
        logic [DATA_W-1:0] data;
        sensor_word_t      word;
        bit                typed;
        motor_word_t       want;
    } stim_row_t;

    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 175;
    localparam int DRAIN_AT     = 60;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    pcs_sensor_if sensor_ch ();
    pcs_motor_if  motor_ch ();

    pump_cascade_staging_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sensor    (sensor_ch),
        .motors    (motor_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Staging predictor state: settings, motors, change marks and tick counter.
    int               lim_block;
    int               lim_unblock;
    int               lim_stage;
    int               lim_unstage;
    bit [31:0]        dly_stage;
    bit [31:0]        dly_unstage;
    bit [TOTAL_W-1:0] cfg_total;
    bit [OPT_W-1:0]   cfg_opts;
    bit [MASK_W-1:0]  run_now;
    bit [31:0]        mark_at [MAX_MOTORS];
    bit [31:0]        tick_now;

    motor_word_t expected_words [$];
    stim_row_t   directed_rows [$];

    int src_idle;
    int sink_idle;
    int mismatch_count;
    int results_seen;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("pump_cascade_staging_unit: mismatch");
        $finish;
    end

    // Hysteresis band: the on edge may lie on either side of the off edge.
    function automatic band_t band_test(int v, int off_lim, int on_lim);
        if (off_lim == on_lim)
            return BAND_GO;
        if (off_lim > on_lim)
        begin
            if (v < on_lim)
                return BAND_GO;
            if (v > off_lim)
                return BAND_STOP;
            return BAND_HOLD;
        end
        if (v > on_lim)
            return BAND_GO;
        if (v < off_lim)
            return BAND_STOP;
        return BAND_HOLD;
    endfunction

    // A motor is held while fewer than the delay ticks passed since its last change.
    function automatic bit motor_held(int m, bit [31:0] dly);
        bit [31:0] age;
        age = tick_now - mark_at[m];
        return (dly != 32'd0) && (age < dly);
    endfunction

    function automatic void switch_motor(int m, bit on);
        run_now[m] = on;
        mark_at[m] = tick_now;
    endfunction

    // One control tick: advances the counter, updates the motors, returns the event.
    function automatic event_t stage_tick(sensor_word_t w);
        int     n;
        int     i;
        int     on_cnt;
        int     last;
        int     val;
        band_t  go;
        event_t e;
        n = (cfg_total == 0) ? 1 : ((cfg_total > MAX_MOTORS) ? MAX_MOTORS : int'(cfg_total));
        tick_now = tick_now + 32'd1;
        e = EV_NONE;
        go = BAND_GO;
        if (cfg_opts[OPT_BLOCK])
            go = band_test(int'(w.block_temp), lim_block, lim_unblock);
        if (go == BAND_HOLD)
            return EV_NONE;

        // Interlock trip: stop every running motor until one is held.
        if (go == BAND_STOP)
        begin
            for (i = 0; i < n; i++)
                if (run_now[i])
                begin
                    if (motor_held(i, dly_unstage))
                        return EV_HELD;
                    switch_motor(i, 1'b0);
                    e = EV_STOP;
                end
            return e;
        end

        // No target control: start every stopped motor until one is held.
        if (!cfg_opts[OPT_TARGET])
        begin
            for (i = 0; i < n; i++)
                if (!run_now[i])
                begin
                    if (motor_held(i, dly_stage))
                        return EV_HELD;
                    switch_motor(i, 1'b1);
                    e = EV_START;
                end
            return e;
        end

        val = int'(w.feed_value);
        if (cfg_opts[OPT_ENTRY])
            val = val - int'(w.entry_value);
        go = band_test(val, lim_unstage, lim_stage);
        if (go == BAND_HOLD)
            return EV_NONE;

        on_cnt = 0;
        last = 0;
        for (i = 0; i < n; i++)
            if (run_now[i])
            begin
                on_cnt++;
                last = i;
            end

        // Unstage the first running motor, but never the last one.
        if (go == BAND_STOP)
        begin
            if (on_cnt <= 1)
                return EV_NONE;
            for (i = 0; i < n; i++)
                if (run_now[i])
                begin
                    if (motor_held(i, dly_unstage))
                        return EV_HELD;
                    switch_motor(i, 1'b0);
                    return EV_STOP;
                end
            return EV_NONE;
        end

        // Stage the next motor in rotation.
        if (on_cnt == n)
            return EV_NONE;
        if (on_cnt == 0)
            i = (int'(w.start_index) < n) ? (int'(w.start_index) + 1) % n : 0;
        else
            i = (last + 1) % n;
        if (motor_held(i, dly_stage))
            return EV_HELD;
        switch_motor(i, 1'b1);
        return EV_START;
    endfunction

    // Directed table builders.
    function automatic void add_cfg(cfg_reg_t r, logic [DATA_W-1:0] d);
        stim_row_t row;
        row.kind = ROW_CFG;
        row.reg_idx = r;
        row.data = d;
        row.word = '{default: '0};
        row.typed = 1'b0;
        row.want = '{mask: '0, ev: EV_NONE};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_word(
        input logic [DATA_W-1:0] bt,
        input logic [DATA_W-1:0] fv,
        input logic [DATA_W-1:0] en,
        input logic [SEED_W-1:0] si,
        input bit                typed = 1'b0,
        input logic [MASK_W-1:0] mask = '0,
        input event_t            ev = EV_NONE
    );
        stim_row_t row;
        row.kind = ROW_WORD;
        row.reg_idx = REG_BLOCK_LIMIT;
        row.data = '0;
        row.word.block_temp = bt;
        row.word.feed_value = fv;
        row.word.entry_value = en;
        row.word.start_index = si;
        row.typed = typed;
        row.want.mask = mask;
        row.want.ev = ev;
        directed_rows.push_back(row);
    endfunction

    // Random values: mostly near the band edges, sometimes anywhere.
    function automatic logic [DATA_W-1:0] near_or_any(int span);
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        return 16'(int'($urandom_range(0, 400)) - 200);
    endfunction

    function automatic sensor_word_t random_word();
        sensor_word_t w;
        w.block_temp = near_or_any(300);
        w.feed_value = near_or_any(300);
        w.entry_value = near_or_any(100);
        w.start_index = 4'($urandom_range(0, 15));
        return w;
    endfunction

    // Register write, mirrored into the predictor.
    task automatic write_reg(cfg_reg_t r, logic [DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        case (r)
            REG_BLOCK_LIMIT:   lim_block = $signed(d);
            REG_UNBLOCK_LIMIT: lim_unblock = $signed(d);
            REG_STAGE_LIMIT:   lim_stage = $signed(d);
            REG_UNSTAGE_LIMIT: lim_unstage = $signed(d);
            REG_STAGE_DELAY:
            begin
                dly_stage = 32'(d);
                tick_now = 32'(d) + 32'd1;
            end
            REG_UNSTAGE_DELAY: dly_unstage = 32'(d);
            REG_MOTOR_TOTAL:   cfg_total = d[TOTAL_W-1:0];
            REG_OPTION_BITS:   cfg_opts = d[OPT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic settle();
        sensor_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Offer one sensor word after a random gap; predict it once accepted.
    task automatic send_word(sensor_word_t w, bit typed, motor_word_t want);
        int          gap;
        motor_word_t got;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < src_idle)
            gap++;
        if (gap > 0)
        begin
            sensor_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_ch.valid <= 1'b1;
        sensor_ch.block_temp <= w.block_temp;
        sensor_ch.feed_value <= w.feed_value;
        sensor_ch.entry_value <= w.entry_value;
        sensor_ch.start_index <= w.start_index;
        @(posedge clk);
        while (!sensor_ch.ready)
            @(posedge clk);
        got.ev = stage_tick(w);
        got.mask = run_now;
        expected_words.push_back(typed ? want : got);
    endtask

    // Result side: random ready, each accepted word checked against the oldest expectation.
    always @(posedge clk)
    begin
        motor_word_t want;
        if (!rst_n)
            motor_ch.ready <= 1'b0;
        else
        begin
            if (motor_ch.valid && motor_ch.ready)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %0d: mask %h event %0d",
                                 results_seen, motor_ch.motor_mask, motor_ch.tick_event);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (motor_ch.motor_mask !== want.mask || motor_ch.tick_event !== want.ev)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result word %0d: expected mask %h event %0d, got mask %h event %0d",
                                     results_seen, want.mask, want.ev,
                                     motor_ch.motor_mask, motor_ch.tick_event);
                    end
                end
            end
            motor_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    // Main sequence.
    initial
    begin
        int            p;
        int            k;
        int            total;
        bit [OPT_W-1:0] opts;
        logic [DATA_W-1:0] lb;
        logic [DATA_W-1:0] ls;
        logic [DATA_W-1:0] sd;
        logic [DATA_W-1:0] ud;
        bit            quiet;
        motor_word_t   none_word;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        sensor_ch.valid <= 1'b0;
        sensor_ch.block_temp <= '0;
        sensor_ch.feed_value <= '0;
        sensor_ch.entry_value <= '0;
        sensor_ch.start_index <= '0;
        mismatch_count = 0;
        results_seen = 0;
        src_idle = 0;
        sink_idle = 0;
        none_word = '{mask: '0, ev: EV_NONE};

        // Predictor reset state.
        lim_block = 0;
        lim_unblock = 0;
        lim_stage = 0;
        lim_unstage = 0;
        dly_stage = 0;
        dly_unstage = 0;
        cfg_total = 5'd1;
        cfg_opts = '0;
        run_now = '0;
        foreach (mark_at[i])
            mark_at[i] = 32'd0;
        tick_now = 32'd1;

        // Directed table: defaults after reset, then band edges, rotation, delays, totals.
        add_word(16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0001, EV_START);
        add_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 1'b1, 16'h0001, EV_NONE);
        add_cfg(REG_MOTOR_TOTAL, 16'd16);
        add_cfg(REG_OPTION_BITS, 16'h0002);
        add_word(16'h8000, 16'h8000, 16'h8000, 4'h0);
        add_word(16'h0000, 16'h0000, 16'h0000, 4'h5);
        add_word(16'h0000, 16'h0000, 16'h0000, 4'hA);
        add_cfg(REG_STAGE_LIMIT, 16'd100);
        add_cfg(REG_UNSTAGE_LIMIT, -16'sd100);
        add_word(16'h0000, 16'h8000, 16'h0000, 4'h0);
        add_word(16'h0000, 16'h0000, 16'h0000, 4'h0);
        add_word(16'h0000, 16'd100, 16'h0000, 4'h0);
        add_word(16'h0000, 16'd101, 16'h0000, 4'h0);
        add_cfg(REG_BLOCK_LIMIT, 16'd50);
        add_cfg(REG_UNBLOCK_LIMIT, -16'sd50);
        add_cfg(REG_OPTION_BITS, 16'h0007);
        add_word(16'h0000, 16'd200, 16'h0000, 4'h0);
        add_word(16'h7FFF, 16'd200, 16'h0000, 4'h0, 1'b1, 16'h0000, EV_STOP);
        add_cfg(REG_MOTOR_TOTAL, 16'd4);
        // Seed beyond the motors in use, then a seed in range.
        add_word(16'h8000, 16'h7FFF, 16'h8000, 4'hF);
        add_word(16'h7FFF, 16'h0000, 16'h0000, 4'h0);
        add_word(-16'sd100, 16'd200, 16'h0000, 4'h2);
        // Unstage with one motor running, then rotation onto a running motor.
        add_word(-16'sd100, -16'sd200, 16'h0000, 4'h0);
        add_word(-16'sd100, 16'd200, 16'h0000, 4'h0);
        add_word(-16'sd100, 16'd200, 16'h0000, 4'h0);
        add_cfg(REG_STAGE_DELAY, 16'hFFFF);
        add_cfg(REG_UNSTAGE_DELAY, 16'hFFFF);
        add_word(-16'sd100, -16'sd200, 16'h0000, 4'h0);
        add_word(-16'sd100, 16'd200, 16'h0000, 4'h0);
        add_word(16'd100, 16'h0000, 16'h0000, 4'h0);
        // Motor totals out of range, upper data bits set.
        add_cfg(REG_STAGE_DELAY, 16'h0000);
        add_cfg(REG_UNSTAGE_DELAY, 16'h0000);
        add_cfg(REG_MOTOR_TOTAL, 16'h0000);
        add_cfg(REG_OPTION_BITS, 16'hFFF8);
        add_word(16'h0000, 16'h0000, 16'h0000, 4'h0);
        add_cfg(REG_MOTOR_TOTAL, 16'hFFFF);
        add_word(16'h0000, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'hFFFF, EV_START);
        add_cfg(REG_OPTION_BITS, 16'hFFFA);
        add_word(16'h0000, 16'd200, 16'h0000, 4'h0, 1'b1, 16'hFFFF, EV_NONE);
        add_word(16'h0000, -16'sd200, 16'h0000, 4'h0);
        // Equal interlock limits always let motors run.
        add_cfg(REG_BLOCK_LIMIT, 16'd7);
        add_cfg(REG_UNBLOCK_LIMIT, 16'd7);
        add_cfg(REG_OPTION_BITS, 16'h0001);
        add_word(16'h8000, 16'h0000, 16'h0000, 4'h0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table; register writes wait until the unit is idle.
        quiet = 1'b1;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                if (!quiet)
                    settle();
                quiet = 1'b1;
                write_reg(directed_rows[r].reg_idx, directed_rows[r].data);
            end
            else
            begin
                quiet = 1'b0;
                send_word(directed_rows[r].word, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random phases, each with its own settings and idle pattern.
        for (p = 0; p < PHASES; p++)
        begin
            settle();
            lb = pick_limit();
            ls = pick_limit();
            write_reg(REG_BLOCK_LIMIT, lb);
            write_reg(REG_UNBLOCK_LIMIT, ($urandom_range(0, 5) == 0) ? lb : pick_limit());
            write_reg(REG_STAGE_LIMIT, ls);
            write_reg(REG_UNSTAGE_LIMIT, ($urandom_range(0, 5) == 0) ? ls : pick_limit());
            if (p == 5)
            begin
                sd = 16'hFFFF;
                ud = 16'hFFFF;
            end
            else if (p % 3 == 0)
            begin
                sd = 16'h0000;
                ud = 16'h0000;
            end
            else
            begin
                sd = 16'($urandom_range(0, 6));
                ud = 16'($urandom_range(0, 6));
            end
            write_reg(REG_STAGE_DELAY, sd);
            write_reg(REG_UNSTAGE_DELAY, ud);
            case (p)
                0: total = 16;
                1: total = 1;
                2: total = 0;
                7: total = 31;
                default: total = $urandom_range(2, 16);
            endcase
            write_reg(REG_MOTOR_TOTAL, (16'($urandom) & 16'hFFE0) | 16'(total));
            if (p == 0)
                opts = 3'b010;
            else
                opts = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0),
                        1'($urandom_range(0, 1))};
            write_reg(REG_OPTION_BITS, (16'($urandom) & 16'hFFF8) | 16'(opts));

            case (p % 4)
                0:
                begin
                    src_idle = 0;
                    sink_idle = 0;
                end
                1:
                begin
                    src_idle = 65;
                    sink_idle = 0;
                end
                2:
                begin
                    src_idle = 0;
                    sink_idle = 65;
                end
                default:
                begin
                    src_idle = 20;
                    sink_idle = 20;
                end
            endcase

            for (k = 0; k < PHASE_WORDS; k++)
            begin
                // Let the result side run dry once per phase.
                if (k == DRAIN_AT)
                    settle();
                send_word(random_word(), 1'b0, none_word);
            end
        end

        // Drain and allow a longest pass before the verdict.
        sensor_ch.valid <= 1'b0;
        sink_idle = 0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("pump_cascade_staging_unit: match");
        else
            $display("pump_cascade_staging_unit: mismatch");
        $finish;
    end

endmodule
